@@ sv/autocorrelation_time_estimator_assert.svh @@
// Assertion helpers for the autocorrelation time estimator.
`ifndef AUTOCORRELATION_TIME_ESTIMATOR_ASSERT_SVH
`define AUTOCORRELATION_TIME_ESTIMATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ace assertion failed");

// antecedent implies consequent in the next cycle
`define ACE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ace assertion failed");

`endif

@@ sv/ace_pkg.sv @@
package ace_pkg;

    localparam int ACE_MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS     = 16;
    localparam int TAU_FRAC_BITS   = 8;
    localparam int GUARD_BITS      = 8;
    localparam int QBITS           = 48;
    localparam int TAU_W           = 21;
    localparam int LAGS_W          = 13;
    // floor(x/10) == (x * RECIP_TENTH) >> RECIP_BITS for x below 2^22
    localparam int RECIP_BITS      = 24;
    localparam int RECIP_TENTH     = (2**RECIP_BITS + 9) / 10;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [0:0] REG_ESTIMATOR_MODE = 1'b0;
    localparam logic       MODE_PER_LAG       = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TEND,
        S_NN,
        S_LAG,
        S_MAC,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_NT,
        S_MM,
        S_DEN,
        S_NUM,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

endpackage

@@ sv/autocorrelation_time_estimator.sv @@
// Integrated autocorrelation time estimator. Samples are loaded one request per
// cycle while busy is low; the request with i_last set starts the computation and
// busy stays high until the single result appears on the o_ ports for exactly one
// cycle with o_valid. The receiver cannot stall that result, so capture it when
// o_valid is high. Per lag t (m = n - t samples) the block streams the m sample
// pairs through one 16x16 multiply-accumulate, then forms the lag numerator and
// denominator on one shared shift-add multiplier (2 products in mode 0 plus 3 for
// the ratio, 5 in mode 1) and one restoring divider. The pair loop dominates the
// run time for long series. The sample buffer has no clearing pass; only samples
// of the current series are read. Configuration: estimator_mode at byte address 0
// (reset 1); the user must write it only while the block is idle, as the block
// itself does not enforce this.
module autocorrelation_time_estimator
    import ace_pkg::*;
#(
    parameter int MAX_SAMPLES = ACE_MAX_SAMPLES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic                           i_last,
    output logic                           o_valid,
    output logic signed [TAU_W-1:0]        o_tau_q8,
    output logic        [LAGS_W-1:0]       o_lags_summed,
    output logic                           o_zero_variance,
    output logic                           o_empty_range,
    output logic                           o_overflowed,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [CFG_ADDR_W-1:0]   paddr,
    input  logic        [CFG_DATA_W-1:0]   pwdata,
    output logic        [CFG_DATA_W-1:0]   prdata,
    output logic                           pready
);

`include "autocorrelation_time_estimator_assert.svh"

    // widths
    localparam int CW    = $clog2(MAX_SAMPLES + 1);      // sample count, lag, m
    localparam int AW    = $clog2(MAX_SAMPLES);          // buffer address
    localparam int SB    = SAMPLE_BITS;
    localparam int SUMW  = SB + CW;                      // S, A, B
    localparam int PW    = 2 * SB + CW;                  // lag product sum
    localparam int MBA   = SUMW + 1;
    localparam int MBB   = 2 * CW + 1;
    localparam int MBC   = RECIP_BITS + 1;
    localparam int MBAB  = (MBA > MBB) ? MBA : MBB;
    localparam int MBW   = (MBAB > MBC) ? MBAB : MBC;    // multiplier operand
    localparam int MCW   = $clog2(MBW);
    localparam int NUMW  = 3 * CW + 2 * SUMW + 4;        // wide terms
    localparam int RSH   = TAU_FRAC_BITS + GUARD_BITS + 1;
    localparam int XW    = NUMW + RSH + 1;               // dividend
    localparam int DYW   = XW + QBITS;
    localparam int QCW   = $clog2(QBITS);
    localparam int ACCW  = QBITS + CW + 1;
    localparam int TENW  = NUMW + 4;

    localparam logic signed [ACCW-1:0] TAU_MAX = ACCW'((2**(TAU_W-1)) - 1);
    localparam logic signed [ACCW-1:0] TAU_MIN = -TAU_MAX - ACCW'(1);

    t_state r_state, n_state;

    // load side
    logic                   r_mode;
    logic [CW-1:0]          r_count;
    logic signed [SUMW-1:0] r_sum;
    logic                   r_drop;
    logic signed [SB-1:0]   r_mem [MAX_SAMPLES];

    // lag loop
    logic [CW-1:0]          r_tend, r_t, r_m, r_k, r_lags;
    logic [2*CW-1:0]        r_nn;
    logic signed [SB-1:0]   r_va, r_vb, r_pa, r_pb;
    logic signed [2*SB-1:0] r_prod;
    logic                   r_v1, r_v2;
    logic signed [PW-1:0]   r_p;
    logic signed [SUMW-1:0] r_ca, r_cb;

    // wide terms
    logic signed [NUMW-1:0] r_t1, r_t2, r_t3, r_n0, r_num, r_den, r_mm;

    // shared shift-add multiplier
    logic signed [NUMW-1:0] r_ma, r_macc;
    logic [MBW-1:0]         r_mb;
    logic [MCW-1:0]         r_mcnt;
    logic                   r_mrun, r_mfin;

    // restoring divider
    logic [XW-1:0]          r_dx;
    logic [DYW-1:0]         r_dy;
    logic [QBITS-1:0]       r_dq;
    logic [QCW-1:0]         r_dcnt;
    logic                   r_dneg, r_drun, r_dfin;

    logic signed [ACCW-1:0] r_acc;
    logic                   r_zero, r_empty;

    // result register
    logic                   r_ovalid;
    logic signed [TAU_W-1:0] r_otau;
    logic [LAGS_W-1:0]      r_olags;
    logic                   r_ozero, r_oempty, r_oovf;

    // combinational
    logic                   w_accept, w_wr, w_cfg_wr, w_is_mul, w_mgo, w_dgo;
    logic                   w_issue, w_mac_end, w_stop, w_last_lag, w_nt_zero;
    logic signed [NUMW-1:0] w_ma, w_madd, w_nt;
    logic [MBW-1:0]         w_mb;
    logic signed [SUMW:0]   w_ab;
    logic [CW-1:0]          w_kt;
    logic signed [XW-1:0]   w_xs, w_y, w_xn;
    logic signed [ACCW-1:0] w_q, w_rnd, w_sh;
    logic signed [TAU_W-1:0] w_tau;
    logic signed [TENW-1:0] w_ten, w_den4;
    logic [0:0]             w_idx;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[CFG_ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (w_idx == REG_ESTIMATOR_MODE) ? CFG_DATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (w_cfg_wr && (w_idx == REG_ESTIMATOR_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    // ---------------- control outputs ----------------
    always_comb begin
        busy      = (r_state != S_IDLE);
        w_accept  = start && !busy;
        w_wr      = w_accept && (r_count < CW'(MAX_SAMPLES));
        w_is_mul  = (r_state == S_TEND) || (r_state == S_NN) || (r_state == S_M1) ||
                    (r_state == S_M2) || (r_state == S_M3) || (r_state == S_M4) ||
                    (r_state == S_M5) || (r_state == S_MM) || (r_state == S_DEN) ||
                    (r_state == S_NUM);
        w_mgo     = w_is_mul && !r_mrun && !r_mfin;
        w_dgo     = (r_state == S_DIV) && !r_drun && !r_dfin;
        w_issue   = (r_state == S_MAC) && (r_k != r_m);
        w_mac_end = (r_state == S_MAC) && (r_k == r_m) && !r_v1 && !r_v2;
        w_last_lag = ((r_t + CW'(1)) == r_tend);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept && i_last) n_state = S_TEND;
            S_TEND: if (r_mfin) n_state = S_NN;
            S_NN:   if (r_mfin) n_state = (r_tend == '0) ? S_DONE : S_LAG;
            S_LAG:  n_state = S_MAC;
            S_MAC:  if (w_mac_end) n_state = S_M1;
            S_M1:   if (r_mfin) n_state = S_M2;
            S_M2: begin
                if (r_mfin) n_state = (r_mode == MODE_PER_LAG) ? S_NT : S_M3;
            end
            S_M3:   if (r_mfin) n_state = S_M4;
            S_M4:   if (r_mfin) n_state = S_M5;
            S_M5:   if (r_mfin) n_state = S_NT;
            S_NT: begin
                priority if (w_nt_zero) n_state = S_DONE;
                else if (r_mode == MODE_PER_LAG) n_state = S_MM;
                else n_state = S_DIV;
            end
            S_MM:   if (r_mfin) n_state = S_DEN;
            S_DEN:  if (r_mfin) n_state = S_NUM;
            S_NUM:  if (r_mfin) n_state = S_DIV;
            S_DIV:  if (r_dfin) n_state = S_ACC;
            S_ACC:  n_state = (w_stop || w_last_lag) ? S_DONE : S_LAG;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- sample buffer and pair loop ----------------
    assign w_kt = r_k + r_t;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_count[AW-1:0]] <= i_sample;
        if (w_issue) begin
            r_va <= r_mem[r_k[AW-1:0]];
            r_vb <= r_mem[w_kt[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // ---------------- multiplier operand select ----------------
    assign w_ab = (SUMW+1)'(r_ca) + (SUMW+1)'(r_cb);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_TEND: begin
                w_ma = (NUMW'(r_count) <<< 3) + NUMW'(r_count);
                w_mb = MBW'(RECIP_TENTH);
            end
            S_NN: begin
                w_ma = NUMW'(r_count);
                w_mb = MBW'(r_count);
            end
            S_M1: begin
                w_ma = NUMW'(r_p);
                w_mb = (r_mode == MODE_PER_LAG) ? MBW'(r_m) : MBW'(r_nn);
            end
            S_M2: begin
                w_ma = (r_mode == MODE_PER_LAG) ? NUMW'(r_ca) : NUMW'(r_sum);
                w_mb = (r_mode == MODE_PER_LAG) ? MBW'(r_cb) : MBW'(r_count);
            end
            S_M3: begin
                w_ma = r_t2;
                w_mb = MBW'(w_ab);
            end
            S_M4: begin
                w_ma = NUMW'(r_sum);
                w_mb = MBW'(r_m);
            end
            S_M5: begin
                w_ma = r_t3;
                w_mb = MBW'(r_sum);
            end
            S_MM: begin
                w_ma = NUMW'(r_m);
                w_mb = MBW'(r_m);
            end
            S_DEN: begin
                w_ma = r_n0;
                w_mb = MBW'(r_mm);
            end
            S_NUM: begin
                w_ma = r_num;
                w_mb = MBW'(r_nn);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // two's complement shift-add: the top operand bit carries negative weight
    assign w_madd = r_mb[0] ? r_ma : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mrun <= 1'b0;
            r_mfin <= 1'b0;
        end else begin
            if (r_state != n_state) r_mfin <= 1'b0;
            if (w_mgo) begin
                r_mrun <= 1'b1;
            end else if (r_mrun && (r_mcnt == MCW'(MBW - 1))) begin
                r_mrun <= 1'b0;
                r_mfin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mgo) begin
            r_ma   <= w_ma;
            r_mb   <= w_mb;
            r_macc <= '0;
            r_mcnt <= '0;
        end else if (r_mrun) begin
            r_macc <= (r_mcnt == MCW'(MBW - 1)) ? r_macc - w_madd : r_macc + w_madd;
            r_ma   <= r_ma <<< 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + MCW'(1);
        end
    end

    // ---------------- lag numerator ----------------
    always_comb begin
        if (r_mode == MODE_PER_LAG) w_nt = r_t1 - r_t2;
        else                        w_nt = r_t1 - r_t2 + r_t3;
        w_nt_zero = (r_t == '0) && (w_nt == '0);
    end

    // ---------------- divider ----------------
    always_comb begin
        w_xs = (XW'(r_num) <<< RSH) + XW'(r_den);
        w_y  = XW'(r_den) <<< 1;
        w_xn = -w_xs + w_y - XW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drun <= 1'b0;
            r_dfin <= 1'b0;
        end else begin
            if (r_state != n_state) r_dfin <= 1'b0;
            if (w_dgo) begin
                r_drun <= 1'b1;
            end else if (r_drun && (r_dcnt == QCW'(QBITS - 1))) begin
                r_drun <= 1'b0;
                r_dfin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dgo) begin
            r_dneg <= w_xs[XW-1];
            r_dx   <= w_xs[XW-1] ? w_xn : w_xs;
            r_dy   <= DYW'(w_y) << (QBITS - 1);
            r_dq   <= '0;
            r_dcnt <= '0;
        end else if (r_drun) begin
            if (r_dy <= DYW'(r_dx)) begin
                r_dx <= r_dx - r_dy[XW-1:0];
                r_dq <= {r_dq[QBITS-2:0], 1'b1};
            end else begin
                r_dq <= {r_dq[QBITS-2:0], 1'b0};
            end
            r_dy   <= r_dy >> 1;
            r_dcnt <= r_dcnt + QCW'(1);
        end
    end

    // ---------------- ratio sum, stop test, final rounding ----------------
    always_comb begin
        w_q    = r_dneg ? -ACCW'(r_dq) : ACCW'(r_dq);
        w_ten  = (TENW'(r_num) <<< 3) + (TENW'(r_num) <<< 1);
        w_den4 = TENW'(r_den);
        w_stop = (w_ten < w_den4);
        w_rnd  = r_acc + (ACCW'(1) <<< (GUARD_BITS - 1));
        w_sh   = w_rnd >>> GUARD_BITS;
        priority if (w_sh > TAU_MAX) w_tau = TAU_W'(TAU_MAX);
        else if (w_sh < TAU_MIN)     w_tau = TAU_W'(TAU_MIN);
        else                         w_tau = TAU_W'(w_sh);
    end

    // ---------------- datapath sequencing ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (r_state == S_DONE) begin
            r_count <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else if (w_accept) begin
            if (w_wr) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + SUMW'(i_sample);
            end else begin
                r_drop  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_acc   <= '0;
            r_lags  <= '0;
            r_t     <= '0;
            r_zero  <= 1'b0;
            r_empty <= 1'b0;
        end
        if (r_v2) begin
            r_p  <= r_p + PW'(r_prod);
            r_ca <= r_ca + SUMW'(r_pa);
            r_cb <= r_cb + SUMW'(r_pb);
        end
        if (r_v1) begin
            r_prod <= r_va * r_vb;
            r_pa   <= r_va;
            r_pb   <= r_vb;
        end
        unique case (r_state)
            S_TEND: if (r_mfin) r_tend <= CW'(r_macc >>> RECIP_BITS);
            S_NN: begin
                if (r_mfin) begin
                    r_nn    <= (2*CW)'(r_macc);
                    r_empty <= (r_tend == '0);
                end
            end
            S_LAG: begin
                r_m  <= r_count - r_t;
                r_k  <= '0;
                r_p  <= '0;
                r_ca <= '0;
                r_cb <= '0;
            end
            S_MAC:  if (w_issue) r_k <= r_k + CW'(1);
            S_M1:   if (r_mfin) r_t1 <= r_macc;
            S_M2:   if (r_mfin) r_t2 <= r_macc;
            S_M3:   if (r_mfin) r_t2 <= r_macc;
            S_M4:   if (r_mfin) r_t3 <= r_macc;
            S_M5:   if (r_mfin) r_t3 <= r_macc;
            S_NT: begin
                r_num <= w_nt;
                if (r_t == '0) begin
                    r_n0 <= w_nt;
                    r_den <= w_nt;
                end else begin
                    r_den <= r_n0;
                end
                if (w_nt_zero) r_zero <= 1'b1;
            end
            S_MM:   if (r_mfin) r_mm  <= r_macc;
            S_DEN:  if (r_mfin) r_den <= r_macc;
            S_NUM:  if (r_mfin) r_num <= r_macc;
            S_ACC: begin
                r_acc  <= r_acc + w_q;
                r_lags <= r_lags + CW'(1);
                r_t    <= r_t + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else          r_ovalid <= (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_otau   <= (r_zero || r_empty) ? '0 : w_tau;
            r_olags  <= (r_zero || r_empty) ? '0 : LAGS_W'(r_lags);
            r_ozero  <= r_zero;
            r_oempty <= r_empty;
            r_oovf   <= r_drop;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_tau_q8        = r_otau;
    assign o_lags_summed   = r_olags;
    assign o_zero_variance = r_ozero;
    assign o_empty_range   = r_oempty;
    assign o_overflowed    = r_oovf;

    // ---------------- assertions ----------------
    `ACE_ASSERT_IMPL(a_result_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    `ACE_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, o_valid, !(o_zero_variance && o_empty_range))
    `ACE_ASSERT_IMPL(a_flag_forces_zero, i_clk, i_rst_n, o_valid && (o_zero_variance || o_empty_range), (o_tau_q8 == '0) && (o_lags_summed == '0))
    `ACE_ASSERT_IMPL(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_SAMPLES))
    `ACE_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, r_state == S_DONE, (r_count == '0) && !r_drop)

endmodule

@@ bench/tb_autocorrelation_time_estimator.sv @@
module tb_autocorrelation_time_estimator;
    import ace_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // one sample request and one expected result record
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_sample_req;

    typedef struct {
        logic signed [TAU_W-1:0]  tau;
        logic        [LAGS_W-1:0] lags;
        logic                     zero_var;
        logic                     empty;
        logic                     ovf;
    } t_tau_result;

    typedef logic signed [255:0] t_wide;

    localparam int IDLE_LIMIT = 100000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_last = 1'b0;
    logic                          o_valid;
    logic signed [TAU_W-1:0]       o_tau_q8;
    logic        [LAGS_W-1:0]      o_lags_summed;
    logic                          o_zero_variance;
    logic                          o_empty_range;
    logic                          o_overflowed;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic        [CFG_ADDR_W-1:0]  paddr = '0;
    logic        [CFG_DATA_W-1:0]  pwdata = '0;
    logic        [CFG_DATA_W-1:0]  prdata;
    logic                          pready;

    autocorrelation_time_estimator dut (
        .i_clk, .i_rst_n, .start, .busy, .i_sample, .i_last,
        .o_valid, .o_tau_q8, .o_lags_summed, .o_zero_variance,
        .o_empty_range, .o_overflowed,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    // stimulus queue and expected-result scoreboard
    t_sample_req pending_reqs[$];
    t_tau_result expected_taus[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;

    // shadow copy of block state
    int          series_buf[ACE_MAX_SAMPLES];
    int          series_len = 0;
    longint      series_sum = 0;
    logic        series_dropped = 1'b0;
    logic        mode_shadow = 1'b1;

    function automatic t_wide floor_div(t_wide x, t_wide y);
        t_wide q;
        q = x / y;
        if (x < 0 && (q * y) != x)
            q = q - 1;
        return q;
    endfunction

    // integrated autocorrelation time of the buffered series
    function automatic t_tau_result estimate_tau();
        t_tau_result r;
        longint      n, tend, m, p_sum, a_sum, b_sum, acc, x;
        t_wide       nt, n0, num, den, nn, sw;
        logic        zero;
        int          lags;
        n    = series_len;
        tend = (9 * n) / 10;
        nn   = n * n;
        sw   = series_sum;
        acc  = 0;
        lags = 0;
        zero = 1'b0;
        n0   = 0;
        for (longint t = 0; t < tend; t++) begin
            m = n - t;
            p_sum = 0; a_sum = 0; b_sum = 0;
            for (longint k = 0; k < m; k++) begin
                p_sum += longint'(series_buf[k]) * longint'(series_buf[k+t]);
                a_sum += series_buf[k];
                b_sum += series_buf[k+t];
            end
            if (mode_shadow == MODE_PER_LAG)
                nt = t_wide'(m) * t_wide'(p_sum) - t_wide'(a_sum) * t_wide'(b_sum);
            else
                nt = nn * t_wide'(p_sum) - t_wide'(n) * sw * t_wide'(a_sum + b_sum)
                     + t_wide'(m) * sw * sw;
            if (t == 0) begin
                n0 = nt;
                if (n0 == 0) begin
                    zero = 1'b1;
                    break;
                end
            end
            if (mode_shadow == MODE_PER_LAG) begin
                num = nt * nn;
                den = n0 * t_wide'(m * m);
            end else begin
                num = nt;
                den = n0;
            end
            acc += longint'(floor_div((num <<< (TAU_FRAC_BITS + GUARD_BITS + 1)) + den,
                                      den <<< 1));
            lags++;
            if (10 * num < den)
                break;
        end
        if (zero || tend == 0) begin
            r.tau  = '0;
            r.lags = '0;
        end else begin
            x = (acc + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
            if (x > 1048575)  x = 1048575;
            if (x < -1048576) x = -1048576;
            r.tau  = x[TAU_W-1:0];
            r.lags = lags[LAGS_W-1:0];
        end
        r.zero_var = zero;
        r.empty    = (tend == 0);
        r.ovf      = series_dropped;
        return r;
    endfunction

    // shadow update for one accepted request
    function automatic void absorb_sample(t_sample_req rq);
        if (series_len < ACE_MAX_SAMPLES) begin
            series_buf[series_len] = rq.sample;
            series_len++;
            series_sum += rq.sample;
        end else begin
            series_dropped = 1'b1;
        end
        if (rq.last) begin
            expected_taus.push_back(estimate_tau());
            series_len = 0;
            series_sum = 0;
            series_dropped = 1'b0;
        end
    endfunction

    // mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int d;
        d = $urandom_range(99);
        if (d < 55) return 0;
        if (d < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: a request is taken at an edge with start high and busy low
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                absorb_sample('{sample: i_sample, last: i_last});
            if (start && busy) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_sample_req rq;
                rq = pending_reqs.pop_front();
                i_sample <= rq.sample;
                i_last <= rq.last;
                start <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results are strobed for one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_taus.size() == 0) begin
                $display("%0t: unexpected result tau=%0d lags=%0d", $time,
                         o_tau_q8, o_lags_summed);
                error_count++;
            end else begin
                t_tau_result e;
                e = expected_taus.pop_front();
                if (o_tau_q8 !== e.tau) begin
                    $display("%0t: tau_q8 exp %0d got %0d", $time, e.tau, o_tau_q8);
                    error_count++;
                end
                if (o_lags_summed !== e.lags) begin
                    $display("%0t: lags_summed exp %0d got %0d", $time, e.lags,
                             o_lags_summed);
                    error_count++;
                end
                if (o_zero_variance !== e.zero_var) begin
                    $display("%0t: zero_variance exp %0b got %0b", $time, e.zero_var,
                             o_zero_variance);
                    error_count++;
                end
                if (o_empty_range !== e.empty) begin
                    $display("%0t: empty_range exp %0b got %0b", $time, e.empty,
                             o_empty_range);
                    error_count++;
                end
                if (o_overflowed !== e.ovf) begin
                    $display("%0t: overflowed exp %0b got %0b", $time, e.ovf,
                             o_overflowed);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_autocorrelation_time_estimator: errors");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // series shapes
    localparam int SH_RANDOM = 0;
    localparam int SH_CONST  = 1;
    localparam int SH_RAMP   = 2;
    localparam int SH_EXTREME = 3;
    localparam int SH_WALK   = 4;

    task automatic add_series(int len, int shape);
        int v;
        v = $urandom_range(0, 4000) - 2000;
        for (int i = 0; i < len; i++) begin
            t_sample_req rq;
            case (shape)
                SH_CONST:   rq.sample = 16'(v);
                SH_RAMP:    rq.sample = 16'(i * 1000 - 15000);
                SH_EXTREME: rq.sample = (i % 2) ? 16'sh7fff : 16'sh8000;
                SH_WALK: begin
                    v = v + $urandom_range(0, 200) - 100;
                    rq.sample = 16'(v);
                end
                default:    rq.sample = 16'($urandom);
            endcase
            rq.last = (i == len - 1);
            pending_reqs.push_back(rq);
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_taus.size() > 0 || start || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(logic val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_ESTIMATOR_MODE, 2'b00};
        pwdata <= {(CFG_DATA_W-1)'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register written at this edge
        mode_shadow = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_series(int budget);
        int used, len, d;
        used = 0;
        while (used < budget) begin
            d = $urandom_range(99);
            if (d < 80) len = $urandom_range(1, 12);
            else len = $urandom_range(13, 40);
            d = $urandom_range(99);
            if (d < 45) add_series(len, SH_RANDOM);
            else if (d < 85) add_series(len, SH_WALK);
            else if (d < 92) add_series(len, SH_CONST);
            else add_series(len, SH_EXTREME);
            used += len;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset mode (mean-removed): short, empty-range, extremes, flat, ramp
        add_series(1, SH_RANDOM);
        add_series(2, SH_EXTREME);
        add_series(4, SH_CONST);
        add_series(16, SH_RAMP);
        wait_idle();

        // per-lag normalised covariance
        write_mode(1'b0);
        add_series(1, SH_CONST);
        add_series(2, SH_RANDOM);
        add_series(5, SH_CONST);
        add_series(6, SH_EXTREME);
        add_series(12, SH_RAMP);
        wait_idle();
        random_series(115);
        wait_idle();

        // back to mean-removed
        write_mode(1'b1);
        random_series(115);
        wait_idle();

        if (error_count == 0)
            $display("tb_autocorrelation_time_estimator: clean");
        else
            $display("tb_autocorrelation_time_estimator: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ace_pkg.sv
sv/autocorrelation_time_estimator.sv
bench/tb_autocorrelation_time_estimator.sv
